>>> rtl/rfo_pkg.sv
// ============================================================================
// rfo_pkg
// Shared widths, codes and constants of the Recaman first-occurrence engine.
// ============================================================================
package rfo_pkg;

    localparam int VAL_W    = 20;   // sequence values and step numbers
    localparam int CNT_W    = 12;   // tracked limit and missing count
    localparam int ENTRY_W  = 21;   // first-occurrence table entry
    localparam int WORD_W   = 64;   // visited bitset word
    localparam int BIT_W    = 6;    // bit position inside a visited word
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 8;

    localparam logic [ENTRY_W-1:0] NOT_SEEN = {ENTRY_W{1'b1}};

    typedef enum logic
    {
        OP_ADVANCE = 1'b0,
        OP_READ    = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        STATUS_RUNNING  = 2'd0,
        STATUS_ALL_SEEN = 2'd1,
        STATUS_HORIZON  = 2'd2,
        STATUS_CAPACITY = 2'd3
    } status_t;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_TRACKED = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZON     = 8'd1;

endpackage

>>> rtl/rfo_ram.sv
// ============================================================================
// rfo_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module rfo_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/recaman_first_occurrence_top.sv
// ============================================================================
// recaman_first_occurrence_top
// Recaman sequence engine with visited bitset and first-occurrence table.
// ============================================================================
//
// Channel   Direction  Signals                          Contents
// --------  ---------  -------------------------------  ---------------------
// s_axis    in         tvalid tready tdata[15:0] tuser  read_index / operation
// m_axis    out        tvalid tready tdata[119:0]       one result per request
// cfg       in         valid ready index[7:0] data[19:0] register writes
//
// Steps: an advance reads the word of v-s, reads the word of the new value,
// writes it back and loads the output; a table read reads the entry first; a
// halted or horizon-limited advance loads the output directly, and one that
// hits the capacity after the first read. Reset and every max_tracked write
// start a clearing pass over both stores; s_axis_tready and cfg_ready stay low.
// A register write waits for the idle state and holds s_axis_tready low while
// cfg_valid is high. A waiting result does not block input; the next result
// holds at output load until the output register frees.
//
module recaman_first_occurrence_top #(
    parameter int VISITED_WORDS = 16384,
    parameter int TABLE_DEPTH   = 4096
) (
    input  logic          clk,
    input  logic          rst_n,

    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [15:0]   s_axis_tdata,   // [11:0] read_index, [15:12] zero
    input  logic          s_axis_tuser,   // [0] operation

    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [19:0] step_index, [39:20] value, [40] is_new, [41] first_recorded,
    // [53:42] remaining, [73:54] max_value, [93:74] deepest_new_step,
    // [95:94] status, [116:96] table_entry, [119:117] zero
    output logic [119:0]  m_axis_tdata,

    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [7:0]    cfg_index,
    input  logic [19:0]   cfg_data
);

    localparam int VAL_W   = rfo_pkg::VAL_W;
    localparam int CNT_W   = rfo_pkg::CNT_W;
    localparam int ENTRY_W = rfo_pkg::ENTRY_W;
    localparam int WORD_W  = rfo_pkg::WORD_W;
    localparam int BIT_W   = rfo_pkg::BIT_W;

    localparam int VW_AW = $clog2(VISITED_WORDS);
    localparam int TB_AW = $clog2(TABLE_DEPTH);
    localparam int VWW   = VW_AW + BIT_W;

    // Values at or above the capacity cannot be stored in the bitset.
    localparam longint CAP_FULL = longint'(VISITED_WORDS) * WORD_W;
    localparam longint CAP      = (CAP_FULL < (64'd1 << VAL_W)) ? CAP_FULL : (64'd1 << VAL_W);
    localparam logic [VAL_W:0] CAP_L = (VAL_W + 1)'(CAP);

    localparam int CLR_DEPTH = (VISITED_WORDS > TABLE_DEPTH) ? VISITED_WORDS : TABLE_DEPTH;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_DEPTH - 1);

    localparam logic [CNT_W-1:0] MT_RESET     = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] MISSING_RST  =
        (TABLE_DEPTH - 1 < 4095) ? CNT_W'(TABLE_DEPTH - 1) : MT_RESET;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_RD,
        ST_ADV1,
        ST_ADV2,
        ST_OUT
    } state_t;

    state_t state_reg;

    // Configuration and architectural state
    logic [CNT_W-1:0]      max_tracked_reg;
    logic [VAL_W-1:0]      horizon_reg;
    logic [VAL_W-1:0]      current_value_reg;
    logic [VAL_W-1:0]      step_count_reg;
    logic [CNT_W-1:0]      missing_reg;
    logic [VAL_W-1:0]      largest_reg;
    logic [VAL_W-1:0]      latest_reg;
    rfo_pkg::status_t      status_reg;

    // Clearing pass
    logic                  clear_active_reg;
    logic [CLR_W-1:0]      clr_cnt_reg;

    // Per-transaction working registers
    logic [VAL_W-1:0]      s_reg;
    logic [VAL_W-1:0]      diff_reg;
    logic                  subok_reg;
    logic [VAL_W:0]        sum_reg;
    logic                  sum_over_reg;
    logic [VAL_W-1:0]      nv_reg;
    logic                  rd_oob_reg;
    logic                  is_new_reg;
    logic                  rec_reg;
    logic [ENTRY_W-1:0]    entry_reg;

    // Output register
    logic                  out_valid_reg;
    logic [119:0]          out_data_reg;

    // RAM ports
    logic                  vis_we;
    logic [VW_AW-1:0]      vis_waddr;
    logic [WORD_W-1:0]     vis_wdata;
    logic [VW_AW-1:0]      vis_raddr;
    logic [WORD_W-1:0]     vis_rdata;
    logic                  tab_we;
    logic [TB_AW-1:0]      tab_waddr;
    logic [ENTRY_W-1:0]    tab_wdata;
    logic [TB_AW-1:0]      tab_raddr;
    logic [ENTRY_W-1:0]    tab_rdata;

    // Combinational helpers
    logic                  in_accept;
    logic [CNT_W-1:0]      tracked_limit;
    logic [CNT_W-1:0]      limit_next;
    logic [VAL_W-1:0]      s_now;
    logic [VAL_W-1:0]      diff_now;
    logic [VWW-1:0]        diff_wide;
    logic                  sub_bit;
    logic                  take_sub;
    logic [VAL_W:0]        nv_pick;
    logic [VWW-1:0]        nv_pick_wide;
    logic [VWW-1:0]        nv_reg_wide;
    logic                  nv_seen;
    logic                  nv_tracked;
    logic                  clr_vis_en;
    logic                  clr_tab_en;

    // Take register writes only between transactions and outside a clearing pass.
    assign cfg_ready     = (state_reg == ST_IDLE) && !clear_active_reg;
    assign s_axis_tready = (state_reg == ST_IDLE) && !clear_active_reg && !cfg_valid;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        tracked_limit = (int'(max_tracked_reg) < TABLE_DEPTH - 1)
                        ? max_tracked_reg : CNT_W'(TABLE_DEPTH - 1);
        limit_next    = (int'(cfg_data[CNT_W-1:0]) < TABLE_DEPTH - 1)
                        ? cfg_data[CNT_W-1:0] : CNT_W'(TABLE_DEPTH - 1);

        s_now     = step_count_reg + VAL_W'(1);
        diff_now  = current_value_reg - s_now;
        diff_wide = VWW'(diff_now);

        // Subtract only if v > s and v - s was never visited.
        sub_bit      = vis_rdata[diff_reg[BIT_W-1:0]];
        take_sub     = subok_reg && !sub_bit;
        nv_pick      = take_sub ? {1'b0, diff_reg} : sum_reg;
        nv_pick_wide = VWW'(nv_pick);
        nv_reg_wide  = VWW'(nv_reg);

        nv_seen    = vis_rdata[nv_reg[BIT_W-1:0]];
        nv_tracked = ({1'b0, nv_reg} <= (VAL_W + 1)'(tracked_limit));

        clr_vis_en = clear_active_reg && (int'(clr_cnt_reg) < VISITED_WORDS);
        clr_tab_en = clear_active_reg && (int'(clr_cnt_reg) < TABLE_DEPTH);
    end

    // Visited bitset ports
    always_comb
    begin
        vis_raddr = (state_reg == ST_ADV1) ? nv_pick_wide[VWW-1:BIT_W]
                                           : diff_wide[VWW-1:BIT_W];
        if (clear_active_reg)
        begin
            vis_we    = clr_vis_en;
            vis_waddr = clr_cnt_reg[VW_AW-1:0];
            vis_wdata = (clr_cnt_reg == '0) ? WORD_W'(1) : '0;
        end
        else
        begin
            vis_we    = (state_reg == ST_ADV2) && !nv_seen;
            vis_waddr = nv_reg_wide[VWW-1:BIT_W];
            vis_wdata = vis_rdata | (WORD_W'(1) << nv_reg[BIT_W-1:0]);
        end
    end

    // First-occurrence table ports
    always_comb
    begin
        tab_raddr = TB_AW'(s_axis_tdata[CNT_W-1:0]);
        if (clear_active_reg)
        begin
            tab_we    = clr_tab_en;
            tab_waddr = clr_cnt_reg[TB_AW-1:0];
            tab_wdata = (clr_cnt_reg == '0) ? '0 : rfo_pkg::NOT_SEEN;
        end
        else
        begin
            tab_we    = (state_reg == ST_ADV2) && !nv_seen && nv_tracked;
            tab_waddr = TB_AW'(nv_reg);
            tab_wdata = ENTRY_W'(s_reg);
        end
    end

    rfo_ram #(
        .WIDTH (WORD_W),
        .DEPTH (VISITED_WORDS)
    ) u_visited (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .raddr (vis_raddr),
        .rdata (vis_rdata)
    );

    rfo_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_first_step (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            max_tracked_reg   <= MT_RESET;
            horizon_reg       <= {VAL_W{1'b1}};
            current_value_reg <= '0;
            step_count_reg    <= '0;
            missing_reg       <= MISSING_RST;
            largest_reg       <= '0;
            latest_reg        <= '0;
            status_reg        <= rfo_pkg::STATUS_RUNNING;
            clear_active_reg  <= 1'b1;
            clr_cnt_reg       <= '0;
            s_reg             <= '0;
            diff_reg          <= '0;
            subok_reg         <= 1'b0;
            sum_reg           <= '0;
            sum_over_reg      <= 1'b0;
            nv_reg            <= '0;
            rd_oob_reg        <= 1'b0;
            is_new_reg        <= 1'b0;
            rec_reg           <= 1'b0;
            entry_reg         <= '0;
            out_valid_reg     <= 1'b0;
            out_data_reg      <= '0;
        end
        else
        begin
            // Sweep both stores back to their restart contents.
            if (clear_active_reg)
            begin
                if (clr_cnt_reg == CLR_LAST)
                begin
                    clear_active_reg <= 1'b0;
                end
                clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
            end

            // Drop the result once taken, unless a new one loads this cycle.
            if (out_valid_reg && m_axis_tready && (state_reg != ST_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        is_new_reg <= 1'b0;
                        rec_reg    <= 1'b0;
                        entry_reg  <= '0;
                        if (s_axis_tuser == rfo_pkg::OP_READ)
                        begin
                            rd_oob_reg <= !(int'(s_axis_tdata[CNT_W-1:0]) < TABLE_DEPTH);
                            state_reg  <= ST_RD;
                        end
                        else if (status_reg != rfo_pkg::STATUS_RUNNING)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else if (step_count_reg >= horizon_reg)
                        begin
                            status_reg <= rfo_pkg::STATUS_HORIZON;
                            state_reg  <= ST_OUT;
                        end
                        else
                        begin
                            s_reg        <= s_now;
                            diff_reg     <= diff_now;
                            subok_reg    <= current_value_reg > s_now;
                            sum_reg      <= {1'b0, current_value_reg} + {1'b0, s_now};
                            sum_over_reg <= ({1'b0, current_value_reg} + {1'b0, s_now})
                                            >= CAP_L;
                            state_reg    <= ST_ADV1;
                        end
                    end
                end

                ST_RD:
                begin
                    entry_reg <= rd_oob_reg ? rfo_pkg::NOT_SEEN : tab_rdata;
                    state_reg <= ST_OUT;
                end

                ST_ADV1:
                begin
                    if (!take_sub && sum_over_reg)
                    begin
                        // Value would leave the bitset: halt without committing.
                        status_reg <= rfo_pkg::STATUS_CAPACITY;
                        state_reg  <= ST_OUT;
                    end
                    else
                    begin
                        nv_reg    <= nv_pick[VAL_W-1:0];
                        state_reg <= ST_ADV2;
                    end
                end

                ST_ADV2:
                begin
                    step_count_reg    <= s_reg;
                    current_value_reg <= nv_reg;
                    if (!nv_seen)
                    begin
                        is_new_reg <= 1'b1;
                        if (nv_reg > largest_reg)
                        begin
                            largest_reg <= nv_reg;
                        end
                    end
                    if (!nv_seen && nv_tracked)
                    begin
                        latest_reg <= s_reg;
                        rec_reg    <= 1'b1;
                        if (missing_reg != '0)
                        begin
                            missing_reg <= missing_reg - CNT_W'(1);
                        end
                    end
                    if (!nv_seen && nv_tracked && (missing_reg == CNT_W'(1)))
                    begin
                        status_reg <= rfo_pkg::STATUS_ALL_SEEN;
                    end
                    else if (s_reg >= horizon_reg)
                    begin
                        status_reg <= rfo_pkg::STATUS_HORIZON;
                    end
                    state_reg <= ST_OUT;
                end

                ST_OUT:
                begin
                    // Hold here until the output register can take the result.
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {3'b000, entry_reg, status_reg, latest_reg,
                                          largest_reg, missing_reg, rec_reg, is_new_reg,
                                          current_value_reg, step_count_reg};
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // Register writes arrive only while the engine is idle.
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == rfo_pkg::REG_MAX_TRACKED)
                begin
                    max_tracked_reg   <= cfg_data[CNT_W-1:0];
                    current_value_reg <= '0;
                    step_count_reg    <= '0;
                    missing_reg       <= limit_next;
                    largest_reg       <= '0;
                    latest_reg        <= '0;
                    status_reg        <= rfo_pkg::STATUS_RUNNING;
                    clear_active_reg  <= 1'b1;
                    clr_cnt_reg       <= '0;
                end
                else if (cfg_index == rfo_pkg::REG_HORIZON)
                begin
                    horizon_reg <= cfg_data;
                end
            end
        end
    end

endmodule

>>> dv/recaman_first_occurrence_top_test.sv
`timescale 1ns / 100ps
// ============================================================================
// recaman_first_occurrence_top_test
// Self-checking bench for the Recaman first-occurrence engine: a directed
// table and random phases, every result checked field by field against typed
// expectations or an in-bench model of the sequence.
// ============================================================================
module recaman_first_occurrence_top_test;

    localparam int VAL_W   = rfo_pkg::VAL_W;
    localparam int CNT_W   = rfo_pkg::CNT_W;
    localparam int ENTRY_W = rfo_pkg::ENTRY_W;

    // Run the stores at their full sizes. Every max_tracked write starts a
    // clearing pass, which the handshakes simply wait out.
    localparam int TB_VISITED_WORDS = 16384;
    localparam int TB_TABLE_DEPTH   = 4096;
    localparam int unsigned VISITED_CAPACITY =
        (TB_VISITED_WORDS * 64 < (1 << 20)) ? TB_VISITED_WORDS * 64 : (1 << 20);
    localparam int WATCHDOG_LIMIT   = 100000;
    localparam int MAX_PRINTED      = 100;

    // Result transaction, packed to match m_axis_tdata from the highest bit down.
    typedef struct packed
    {
        logic [2:0]          pad;
        logic [ENTRY_W-1:0]  table_entry;
        rfo_pkg::status_t    status;
        logic [VAL_W-1:0]    deepest_new_step;
        logic [VAL_W-1:0]    max_value;
        logic [CNT_W-1:0]    remaining;
        logic                first_recorded;
        logic                is_new;
        logic [VAL_W-1:0]    value;
        logic [VAL_W-1:0]    step_index;
    } engine_result_t;

    typedef enum logic [1:0]
    {
        ROW_ADVANCE,
        ROW_READ,
        ROW_CFG
    } row_kind_t;

    // One line of the directed table. For ROW_CFG, reg_sel is the register
    // index and arg the data; for requests, arg[11:0] is the read index.
    typedef struct
    {
        row_kind_t       kind;
        logic [7:0]      reg_sel;
        logic [19:0]     arg;
        bit              typed;
        engine_result_t  want;
    } stim_row_t;

    logic          clk;
    logic          rst_n          = 1'b0;
    logic          s_axis_tvalid  = 1'b0;
    logic          s_axis_tready;
    logic [15:0]   s_axis_tdata   = '0;   // [11:0] read_index, [15:12] zero
    logic          s_axis_tuser   = 1'b0; // [0] operation
    logic          m_axis_tvalid;
    logic          m_axis_tready  = 1'b0;
    // [19:0] step_index, [39:20] value, [40] is_new, [41] first_recorded,
    // [53:42] remaining, [73:54] max_value, [93:74] deepest_new_step,
    // [95:94] status, [116:96] table_entry, [119:117] zero
    logic [119:0]  m_axis_tdata;
    logic          cfg_valid      = 1'b0;
    logic          cfg_ready;
    logic [7:0]    cfg_index      = '0;
    logic [19:0]   cfg_data       = '0;

    recaman_first_occurrence_top #(
        .VISITED_WORDS (TB_VISITED_WORDS),
        .TABLE_DEPTH   (TB_TABLE_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Sequence model: its own visited set, first-step table and counters
    // ------------------------------------------------------------------------
    bit                  seen_values [int];
    logic [ENTRY_W-1:0]  first_step [0:TB_TABLE_DEPTH-1];
    logic [VAL_W-1:0]    model_value;
    logic [VAL_W-1:0]    model_step;
    logic [VAL_W-1:0]    model_largest;
    logic [VAL_W-1:0]    model_latest_first;
    logic [CNT_W-1:0]    model_missing;
    rfo_pkg::status_t    model_status;
    logic [CNT_W-1:0]    model_max_tracked = 12'd4095;
    logic [VAL_W-1:0]    model_horizon     = 20'd1048575;

    engine_result_t      expected_outcomes [$];
    int                  error_count = 0;
    int                  burst_left  = 0;
    bit                  sender_steady = 1'b0;

    function automatic int unsigned tracked_limit();
        return (model_max_tracked < TB_TABLE_DEPTH - 1) ? model_max_tracked
                                                        : TB_TABLE_DEPTH - 1;
    endfunction

    // Clear both stores and all counters, as reset and a max_tracked write do.
    task automatic restart_sequence_model();
        seen_values.delete();
        seen_values[0] = 1'b1;
        for (int i = 0; i < TB_TABLE_DEPTH; i++)
            first_step[i] = rfo_pkg::NOT_SEEN;
        first_step[0]      = '0;
        model_value        = '0;
        model_step         = '0;
        model_largest      = '0;
        model_latest_first = '0;
        model_missing      = CNT_W'(tracked_limit());
        model_status       = rfo_pkg::STATUS_RUNNING;
    endtask

    // Apply one request to the model and return the result it causes.
    function automatic engine_result_t compute_outcome(input rfo_pkg::op_t op,
                                                       input logic [11:0] idx);
        engine_result_t   r;
        int unsigned      s;
        int unsigned      v;
        int unsigned      nv;
        bit               fresh;
        bit               recorded;
        logic [ENTRY_W-1:0] entry;
        fresh    = 1'b0;
        recorded = 1'b0;
        entry    = '0;
        if (op == rfo_pkg::OP_READ)
        begin
            entry = (idx < TB_TABLE_DEPTH) ? first_step[idx] : rfo_pkg::NOT_SEEN;
        end
        else if (model_status == rfo_pkg::STATUS_RUNNING)
        begin
            if (model_step >= model_horizon)
            begin
                model_status = rfo_pkg::STATUS_HORIZON;
            end
            else
            begin
                s = model_step + 1;
                v = model_value;
                if (v > s && !seen_values.exists(v - s))
                    nv = v - s;
                else
                    nv = v + s;
                if (nv >= VISITED_CAPACITY)
                begin
                    // Step would leave the visited store: halt, commit nothing.
                    model_status = rfo_pkg::STATUS_CAPACITY;
                end
                else
                begin
                    model_step  = VAL_W'(s);
                    model_value = VAL_W'(nv);
                    if (!seen_values.exists(nv))
                    begin
                        fresh = 1'b1;
                        seen_values[nv] = 1'b1;
                        if (nv > model_largest)
                            model_largest = VAL_W'(nv);
                        if (nv <= tracked_limit() && first_step[nv] == rfo_pkg::NOT_SEEN)
                        begin
                            first_step[nv]     = ENTRY_W'(s);
                            model_latest_first = VAL_W'(s);
                            recorded           = 1'b1;
                            if (model_missing > 0)
                            begin
                                model_missing--;
                                if (model_missing == 0)
                                    model_status = rfo_pkg::STATUS_ALL_SEEN;
                            end
                        end
                    end
                    // Completing the tracked set wins over the horizon.
                    if (model_status == rfo_pkg::STATUS_RUNNING &&
                        model_step >= model_horizon)
                        model_status = rfo_pkg::STATUS_HORIZON;
                end
            end
        end
        r.pad              = '0;
        r.step_index       = model_step;
        r.value            = model_value;
        r.is_new           = fresh;
        r.first_recorded   = recorded;
        r.remaining        = model_missing;
        r.max_value        = model_largest;
        r.deepest_new_step = model_latest_first;
        r.status           = model_status;
        r.table_entry      = entry;
        return r;
    endfunction

    function automatic engine_result_t outcome(input logic [19:0] st,
                                               input logic [19:0] val,
                                               input bit nw,
                                               input bit rc,
                                               input logic [11:0] rem,
                                               input logic [19:0] mx,
                                               input logic [19:0] dp,
                                               input rfo_pkg::status_t sts,
                                               input logic [20:0] ent);
        engine_result_t r;
        r.pad              = '0;
        r.step_index       = st;
        r.value            = val;
        r.is_new           = nw;
        r.first_recorded   = rc;
        r.remaining        = rem;
        r.max_value        = mx;
        r.deepest_new_step = dp;
        r.status           = sts;
        r.table_entry      = ent;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Error reporting and result checking
    // ------------------------------------------------------------------------
    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            report_error($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Pop the oldest expectation for every result transaction and compare.
    always @(posedge clk)
    begin : result_check
        engine_result_t got;
        engine_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = engine_result_t'(m_axis_tdata);
            if (expected_outcomes.size() == 0)
            begin
                report_error("result transaction with no request outstanding");
            end
            else
            begin
                want = expected_outcomes.pop_front();
                check_field("step_index", got.step_index, want.step_index);
                check_field("value", got.value, want.value);
                check_field("is_new", got.is_new, want.is_new);
                check_field("first_recorded", got.first_recorded, want.first_recorded);
                check_field("remaining", got.remaining, want.remaining);
                check_field("max_value", got.max_value, want.max_value);
                check_field("deepest_new_step", got.deepest_new_step,
                            want.deepest_new_step);
                check_field("status", got.status, want.status);
                check_field("table_entry", got.table_entry, want.table_entry);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: keep picking a random stall mode among always ready, a repeating
    // random bit pattern and coin flips.
    // ------------------------------------------------------------------------
    logic [15:0] stall_pattern = 16'hFFFF;
    logic [1:0]  rx_mode       = 2'd0;
    logic [15:0] rx_count      = '0;

    always @(posedge clk)
    begin
        rx_count <= rx_count + 16'd1;
        if (rx_count[6:0] == 7'd0)
        begin
            rx_mode       <= 2'($urandom_range(0, 2));
            stall_pattern <= 16'($urandom);
        end
        case (rx_mode)
            2'd0:    m_axis_tready <= 1'b1;
            2'd1:    m_axis_tready <= stall_pattern[rx_count[3:0]];
            default: m_axis_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no transaction moves for too long.
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Present one request and hold it until accepted, then predict it. Keep
    // tvalid high into the next request unless a gap follows the burst.
    task automatic send_request(input rfo_pkg::op_t op, input logic [11:0] idx,
                                input bit typed, input engine_result_t typed_want);
        engine_result_t predicted;
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, idx};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = compute_outcome(op, idx);
        expected_outcomes.push_back(typed ? typed_want : predicted);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0 && !sender_steady)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Drop tvalid, then wait until every expected result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // Write one register while the engine is idle and mirror it in the model.
    task automatic write_register(input logic [7:0] reg_sel, input logic [19:0] val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= reg_sel;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (reg_sel == rfo_pkg::REG_MAX_TRACKED)
        begin
            model_max_tracked = val[CNT_W-1:0];
            restart_sequence_model();
        end
        else if (reg_sel == rfo_pkg::REG_HORIZON)
        begin
            model_horizon = val;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        stim_row_t       rows [$];
        engine_result_t  none;
        rfo_pkg::op_t    op;
        logic [11:0]     idx;
        logic [11:0]     tracked_sel;
        logic [19:0]     horizon_sel;
        int              n_items;
        int              pause_at;

        none = '0;
        restart_sequence_model();

        // Hold reset low at the start; the engine then runs its clearing pass,
        // which the handshakes below simply wait out.
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table. Typed expectations cover the state after reset,
        // the table edges and the halting cases; the rest uses the model.
        rows.push_back('{ROW_READ, 8'd0, 20'd0, 1'b1,
                         outcome(0, 0, 0, 0, 4095, 0, 0, rfo_pkg::STATUS_RUNNING, 0)});
        // last table entry, not reached yet
        rows.push_back('{ROW_READ, 8'd0, 20'd4095, 1'b1,
                         outcome(0, 0, 0, 0, 4095, 0, 0, rfo_pkg::STATUS_RUNNING,
                                 rfo_pkg::NOT_SEEN)});
        rows.push_back('{ROW_ADVANCE, 8'd0, 20'd0, 1'b1,
                         outcome(1, 1, 1, 1, 4094, 1, 1, rfo_pkg::STATUS_RUNNING, 0)});
        rows.push_back('{ROW_ADVANCE, 8'd0, 20'd0, 1'b0, none});
        rows.push_back('{ROW_ADVANCE, 8'd0, 20'd0, 1'b0, none});
        // first downward step: 6 - 4 = 2
        rows.push_back('{ROW_ADVANCE, 8'd0, 20'd0, 1'b0, none});
        rows.push_back('{ROW_READ, 8'd0, 20'd2, 1'b0, none});
        rows.push_back('{ROW_READ, 8'd0, 20'd255, 1'b0, none});
        // small tracked set: completes at step 4, then every advance is halted
        rows.push_back('{ROW_CFG, rfo_pkg::REG_MAX_TRACKED, 20'd3, 1'b0, none});
        repeat (5) rows.push_back('{ROW_ADVANCE, 8'd0, 20'd0, 1'b0, none});
        rows.push_back('{ROW_READ, 8'd0, 20'd3, 1'b0, none});
        // last step completes the tracked set: status all-seen, not horizon
        rows.push_back('{ROW_CFG, rfo_pkg::REG_HORIZON, 20'd1, 1'b0, none});
        rows.push_back('{ROW_CFG, rfo_pkg::REG_MAX_TRACKED, 20'd1, 1'b0, none});
        rows.push_back('{ROW_ADVANCE, 8'd0, 20'd0, 1'b1,
                         outcome(1, 1, 1, 1, 0, 1, 1, rfo_pkg::STATUS_ALL_SEEN, 0)});
        rows.push_back('{ROW_ADVANCE, 8'd0, 20'd0, 1'b1,
                         outcome(1, 1, 0, 0, 0, 1, 1, rfo_pkg::STATUS_ALL_SEEN, 0)});
        // nothing tracked: only the horizon stops the run
        rows.push_back('{ROW_CFG, rfo_pkg::REG_MAX_TRACKED, 20'd0, 1'b0, none});
        rows.push_back('{ROW_ADVANCE, 8'd0, 20'd0, 1'b1,
                         outcome(1, 1, 1, 0, 0, 1, 0, rfo_pkg::STATUS_HORIZON, 0)});
        rows.push_back('{ROW_READ, 8'd0, 20'd1, 1'b1,
                         outcome(1, 1, 0, 0, 0, 1, 0, rfo_pkg::STATUS_HORIZON,
                                 rfo_pkg::NOT_SEEN)});
        // horizon already reached before the first step
        rows.push_back('{ROW_CFG, rfo_pkg::REG_HORIZON, 20'd0, 1'b0, none});
        rows.push_back('{ROW_CFG, rfo_pkg::REG_MAX_TRACKED, 20'd4095, 1'b0, none});
        rows.push_back('{ROW_ADVANCE, 8'd0, 20'd0, 1'b1,
                         outcome(0, 0, 0, 0, 4095, 0, 0, rfo_pkg::STATUS_HORIZON, 0)});
        // writes to unknown register indexes must change nothing
        rows.push_back('{ROW_CFG, 8'd2, 20'h5A5A5, 1'b0, none});
        rows.push_back('{ROW_CFG, 8'hFF, 20'hFFFFF, 1'b0, none});
        rows.push_back('{ROW_READ, 8'd0, 20'd0, 1'b1,
                         outcome(0, 0, 0, 0, 4095, 0, 0, rfo_pkg::STATUS_HORIZON, 0)});

        foreach (rows[i])
        begin
            case (rows[i].kind)
                ROW_CFG:     write_register(rows[i].reg_sel, rows[i].arg);
                ROW_READ:    send_request(rfo_pkg::OP_READ, rows[i].arg[11:0],
                                          rows[i].typed, rows[i].want);
                default:     send_request(rfo_pkg::OP_ADVANCE, rows[i].arg[11:0],
                                          rows[i].typed, rows[i].want);
            endcase
        end

        // Random phases: new settings each time, mostly advances with reads
        // mixed in; half the reads go to small values the run reaches early.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       begin tracked_sel = 12'd4095; horizon_sel = 20'd1048575; end
                1:       begin tracked_sel = 12'($urandom_range(1, 8));
                               horizon_sel = 20'($urandom_range(20, 400)); end
                2:       begin tracked_sel = 12'd0; horizon_sel = 20'd1; end
                default: begin tracked_sel = 12'($urandom_range(0, 4095));
                               horizon_sel = ($urandom_range(0, 1) == 0)
                                           ? 20'($urandom_range(1, 600))
                                           : 20'($urandom_range(1, 1048575)); end
            endcase
            write_register(rfo_pkg::REG_HORIZON, horizon_sel);
            write_register(rfo_pkg::REG_MAX_TRACKED, {8'd0, tracked_sel});
            sender_steady = ($urandom_range(0, 3) == 0);
            n_items  = (phase == 2) ? 20 : $urandom_range(60, 90);
            pause_at = $urandom_range(5, n_items - 5);
            for (int k = 0; k < n_items; k++)
            begin
                // hold off until the engine has emptied out once per phase
                if (k == pause_at)
                    drain_results();
                op  = ($urandom_range(0, 9) < 8) ? rfo_pkg::OP_ADVANCE : rfo_pkg::OP_READ;
                idx = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 63))
                                                  : 12'($urandom_range(0, 4095));
                send_request(op, idx, 1'b0, none);
            end
        end

        // Wait out the last results, then keep the clock running so that
        // any stray result transaction still gets flagged.
        drain_results();
        repeat (20) @(posedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
